// ===== rtl/scmp_pkg.sv =====
package scmp_pkg;

  localparam int SCMP_DATA_WIDTH = 32;
  localparam int SCMP_FRAC_BITS  = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 31;
  localparam int PC_W            = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCELERATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RAMP_TIME  = 2'd2;

  localparam logic CMD_SET_GOAL = 1'b0;
  localparam logic CMD_UPDATE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER
  } state_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_ABS, OP_MAX0, OP_MOV,
    OP_NEGD, OP_CLT, OP_CGT, OP_BR, OP_BCMD, OP_JMP, OP_PH, OP_DONE
  } op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_HALF, S_TQ, S_VM, S_A, S_T, S_J, S_P,
    S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
    S_DSP, S_VSP, S_ASP, S_X0, S_X1, S_X2,
    S_GOAL, S_SRCD, S_SRCV, S_SRCA, S_NOW, S_DT
  } src_t;

  typedef struct packed {
    op_t             op;
    src_t            a;
    src_t            b;
    src_t            d;
    logic [PC_W-1:0] imm;
  } uinst_t;

  localparam logic [PC_W-1:0] PC_SHORT  = 7'd14;
  localparam logic [PC_W-1:0] PC_COMMON = 7'd27;
  localparam logic [PC_W-1:0] PC_UPD    = 7'd35;
  localparam logic [PC_W-1:0] PC_P0     = 7'd53;
  localparam logic [PC_W-1:0] PC_P1     = 7'd59;
  localparam logic [PC_W-1:0] PC_P2     = 7'd65;
  localparam logic [PC_W-1:0] PC_P3     = 7'd75;
  localparam logic [PC_W-1:0] PC_P4     = 7'd79;
  localparam logic [PC_W-1:0] PC_P5     = 7'd88;
  localparam logic [PC_W-1:0] PC_P6     = 7'd97;
  localparam logic [PC_W-1:0] PC_FIN    = 7'd105;

  localparam logic [PC_W-1:0] PH_0 = 7'd0;
  localparam logic [PC_W-1:0] PH_1 = 7'd1;
  localparam logic [PC_W-1:0] PH_2 = 7'd2;
  localparam logic [PC_W-1:0] PH_3 = 7'd3;
  localparam logic [PC_W-1:0] PH_4 = 7'd4;
  localparam logic [PC_W-1:0] PH_5 = 7'd5;
  localparam logic [PC_W-1:0] PH_6 = 7'd6;
  localparam logic [PC_W-1:0] PH_7 = 7'd7;

  function automatic uinst_t mk(op_t op, src_t a, src_t b, src_t d, logic [PC_W-1:0] imm);
    uinst_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.d   = d;
    u.imm = imm;
    return u;
  endfunction

  function automatic uinst_t ucode(logic [PC_W-1:0] pc);
    uinst_t u;
    unique case (pc)
      7'd0:   u = mk(OP_DIV,  S_A,    S_T,    S_J,    '0);
      7'd1:   u = mk(OP_BCMD, S_ZERO, S_ZERO, S_ZERO, PC_UPD);
      // set goal
      7'd2:   u = mk(OP_SUB,  S_GOAL, S_SRCD, S_X0,   '0);
      7'd3:   u = mk(OP_ABS,  S_X0,   S_ZERO, S_X0,   '0);
      7'd4:   u = mk(OP_DIV,  S_VM,   S_A,    S_X1,   '0);
      7'd5:   u = mk(OP_ADD,  S_T,    S_X1,   S_X1,   '0);
      7'd6:   u = mk(OP_MUL,  S_VM,   S_X1,   S_X1,   '0);
      7'd7:   u = mk(OP_CGT,  S_X1,   S_X0,   S_ZERO, '0);
      7'd8:   u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_SHORT);
      7'd9:   u = mk(OP_MOV,  S_VM,   S_ZERO, S_P,    '0);
      7'd10:  u = mk(OP_DIV,  S_P,    S_A,    S_T2,   '0);
      7'd11:  u = mk(OP_ADD,  S_T2,   S_T,    S_T3,   '0);
      7'd12:  u = mk(OP_DIV,  S_X0,   S_P,    S_T4,   '0);
      7'd13:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_COMMON);
      7'd14:  u = mk(OP_DIV,  S_X0,   S_A,    S_X1,   '0);
      7'd15:  u = mk(OP_MUL,  S_T,    S_T,    S_X2,   '0);
      7'd16:  u = mk(OP_MUL,  S_TQ,   S_X2,   S_X2,   '0);
      7'd17:  u = mk(OP_SUB,  S_X1,   S_X2,   S_X1,   '0);
      7'd18:  u = mk(OP_MAX0, S_X1,   S_ZERO, S_X1,   '0);
      7'd19:  u = mk(OP_SQRT, S_X1,   S_ZERO, S_X1,   '0);
      7'd20:  u = mk(OP_MUL,  S_HALF, S_T,    S_X2,   '0);
      7'd21:  u = mk(OP_SUB,  S_X1,   S_X2,   S_X1,   '0);
      7'd22:  u = mk(OP_MUL,  S_A,    S_X1,   S_X1,   '0);
      7'd23:  u = mk(OP_MAX0, S_X1,   S_ZERO, S_P,    '0);
      7'd24:  u = mk(OP_DIV,  S_P,    S_A,    S_T2,   '0);
      7'd25:  u = mk(OP_ADD,  S_T2,   S_T,    S_T3,   '0);
      7'd26:  u = mk(OP_MOV,  S_T3,   S_ZERO, S_T4,   '0);
      7'd27:  u = mk(OP_ADD,  S_T4,   S_T,    S_T5,   '0);
      7'd28:  u = mk(OP_ADD,  S_T4,   S_T2,   S_T6,   '0);
      7'd29:  u = mk(OP_ADD,  S_T6,   S_T,    S_T7,   '0);
      7'd30:  u = mk(OP_MOV,  S_SRCD, S_ZERO, S_DSP,  '0);
      7'd31:  u = mk(OP_MOV,  S_SRCV, S_ZERO, S_VSP,  '0);
      7'd32:  u = mk(OP_MOV,  S_SRCA, S_ZERO, S_ASP,  '0);
      7'd33:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_0);
      7'd34:  u = mk(OP_DONE, S_ZERO, S_ZERO, S_ZERO, '0);
      // update: phase search
      7'd35:  u = mk(OP_CLT,  S_NOW,  S_T,    S_ZERO, '0);
      7'd36:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P0);
      7'd37:  u = mk(OP_CLT,  S_NOW,  S_T2,   S_ZERO, '0);
      7'd38:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P1);
      7'd39:  u = mk(OP_CLT,  S_NOW,  S_T3,   S_ZERO, '0);
      7'd40:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P2);
      7'd41:  u = mk(OP_CLT,  S_NOW,  S_T4,   S_ZERO, '0);
      7'd42:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P3);
      7'd43:  u = mk(OP_CLT,  S_NOW,  S_T5,   S_ZERO, '0);
      7'd44:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P4);
      7'd45:  u = mk(OP_CLT,  S_NOW,  S_T6,   S_ZERO, '0);
      7'd46:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P5);
      7'd47:  u = mk(OP_CLT,  S_NOW,  S_T7,   S_ZERO, '0);
      7'd48:  u = mk(OP_BR,   S_ZERO, S_ZERO, S_ZERO, PC_P6);
      7'd49:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_7);
      7'd50:  u = mk(OP_MOV,  S_ZERO, S_ZERO, S_X0,   '0);
      7'd51:  u = mk(OP_MOV,  S_ZERO, S_ZERO, S_X1,   '0);
      7'd52:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd53:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_0);
      7'd54:  u = mk(OP_MUL,  S_J,    S_NOW,  S_X0,   '0);
      7'd55:  u = mk(OP_MUL,  S_NOW,  S_NOW,  S_X1,   '0);
      7'd56:  u = mk(OP_MUL,  S_J,    S_X1,   S_X1,   '0);
      7'd57:  u = mk(OP_MUL,  S_HALF, S_X1,   S_X1,   '0);
      7'd58:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd59:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_1);
      7'd60:  u = mk(OP_MOV,  S_A,    S_ZERO, S_X0,   '0);
      7'd61:  u = mk(OP_MUL,  S_HALF, S_T,    S_X1,   '0);
      7'd62:  u = mk(OP_SUB,  S_NOW,  S_X1,   S_X1,   '0);
      7'd63:  u = mk(OP_MUL,  S_A,    S_X1,   S_X1,   '0);
      7'd64:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd65:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_2);
      7'd66:  u = mk(OP_SUB,  S_NOW,  S_T2,   S_X2,   '0);
      7'd67:  u = mk(OP_MUL,  S_J,    S_X2,   S_X2,   '0);
      7'd68:  u = mk(OP_SUB,  S_A,    S_X2,   S_X0,   '0);
      7'd69:  u = mk(OP_SUB,  S_T3,   S_NOW,  S_X2,   '0);
      7'd70:  u = mk(OP_MUL,  S_X2,   S_X2,   S_X2,   '0);
      7'd71:  u = mk(OP_MUL,  S_J,    S_X2,   S_X2,   '0);
      7'd72:  u = mk(OP_MUL,  S_HALF, S_X2,   S_X2,   '0);
      7'd73:  u = mk(OP_SUB,  S_P,    S_X2,   S_X1,   '0);
      7'd74:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd75:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_3);
      7'd76:  u = mk(OP_MOV,  S_ZERO, S_ZERO, S_X0,   '0);
      7'd77:  u = mk(OP_MOV,  S_P,    S_ZERO, S_X1,   '0);
      7'd78:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd79:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_4);
      7'd80:  u = mk(OP_SUB,  S_NOW,  S_T4,   S_X2,   '0);
      7'd81:  u = mk(OP_MUL,  S_J,    S_X2,   S_X0,   '0);
      7'd82:  u = mk(OP_SUB,  S_ZERO, S_X0,   S_X0,   '0);
      7'd83:  u = mk(OP_MUL,  S_X2,   S_X2,   S_X2,   '0);
      7'd84:  u = mk(OP_MUL,  S_J,    S_X2,   S_X2,   '0);
      7'd85:  u = mk(OP_MUL,  S_HALF, S_X2,   S_X2,   '0);
      7'd86:  u = mk(OP_SUB,  S_P,    S_X2,   S_X1,   '0);
      7'd87:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd88:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_5);
      7'd89:  u = mk(OP_SUB,  S_ZERO, S_A,    S_X0,   '0);
      7'd90:  u = mk(OP_MUL,  S_A,    S_T,    S_X1,   '0);
      7'd91:  u = mk(OP_MUL,  S_HALF, S_X1,   S_X1,   '0);
      7'd92:  u = mk(OP_SUB,  S_P,    S_X1,   S_X1,   '0);
      7'd93:  u = mk(OP_SUB,  S_NOW,  S_T5,   S_X2,   '0);
      7'd94:  u = mk(OP_MUL,  S_A,    S_X2,   S_X2,   '0);
      7'd95:  u = mk(OP_SUB,  S_X1,   S_X2,   S_X1,   '0);
      7'd96:  u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd97:  u = mk(OP_PH,   S_ZERO, S_ZERO, S_ZERO, PH_6);
      7'd98:  u = mk(OP_SUB,  S_T7,   S_NOW,  S_X2,   '0);
      7'd99:  u = mk(OP_MUL,  S_J,    S_X2,   S_X0,   '0);
      7'd100: u = mk(OP_SUB,  S_ZERO, S_X0,   S_X0,   '0);
      7'd101: u = mk(OP_MUL,  S_X2,   S_X2,   S_X2,   '0);
      7'd102: u = mk(OP_MUL,  S_J,    S_X2,   S_X2,   '0);
      7'd103: u = mk(OP_MUL,  S_HALF, S_X2,   S_X1,   '0);
      7'd104: u = mk(OP_JMP,  S_ZERO, S_ZERO, S_ZERO, PC_FIN);
      7'd105: u = mk(OP_NEGD, S_X0,   S_ZERO, S_ASP,  '0);
      7'd106: u = mk(OP_NEGD, S_X1,   S_ZERO, S_VSP,  '0);
      7'd107: u = mk(OP_MUL,  S_VSP,  S_DT,   S_X2,   '0);
      7'd108: u = mk(OP_ADD,  S_DSP,  S_X2,   S_DSP,  '0);
      default: u = mk(OP_DONE, S_ZERO, S_ZERO, S_ZERO, '0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/scmp_if.sv =====
interface scmp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] time_now;
  logic [31:0] goal_displacement;
  logic [31:0] source_displacement;
  logic [31:0] source_velocity;
  logic [31:0] source_acceleration;

  modport source (output valid, cmd, time_now, goal_displacement, source_displacement,
                  source_velocity, source_acceleration, input ready);
  modport sink (input valid, cmd, time_now, goal_displacement, source_displacement,
                source_velocity, source_acceleration, output ready);
endinterface

interface scmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] setpoint_displacement;
  logic [31:0] setpoint_velocity;
  logic [31:0] setpoint_acceleration;
  logic [2:0]  profile_phase;

  modport source (output valid, setpoint_displacement, setpoint_velocity,
                  setpoint_acceleration, profile_phase, input ready);
  modport sink (input valid, setpoint_displacement, setpoint_velocity,
                setpoint_acceleration, profile_phase, output ready);
endinterface

// ===== rtl/s_curve_motion_profile.sv =====
// Microcoded sequencer around one shared ALU and one radix-2 divide/sqrt unit.
// A divide or sqrt holds the sequencer in its iterate state until done. Data is Q16.16.
// An update item runs one divide plus the phase search; a set-goal item runs four
// divides (long move) or four divides and one sqrt (short move). One item at a time;
// input ready again the cycle after; a finished result waits in the output register
// while the next item runs. Synchronous active-low reset: limits to 1.0, state to zero.
module s_curve_motion_profile import scmp_pkg::*; #(
  parameter int DATA_WIDTH = SCMP_DATA_WIDTH,
  parameter int FRAC_BITS  = SCMP_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scmp_in_if.sink               in_ch,
  scmp_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int W2 = 2 * W;
  localparam int WX = 2 * W + F + 2;
  localparam int DV = W + F;
  localparam int NS = (DV + 1) / 2;
  localparam int XW = 2 * NS;
  localparam int RW = (W + 1 > NS + 3) ? W + 1 : NS + 3;
  localparam int QW = DV;
  localparam int CW = $clog2(XW + 1);

  localparam logic signed [WX-1:0] SMAX_X = {{(WX-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [WX-1:0] SMIN_X = ~SMAX_X;
  localparam logic signed [W-1:0]  SMAX_W = SMAX_X[W-1:0];
  localparam logic signed [W-1:0]  SMIN_W = SMIN_X[W-1:0];
  localparam logic signed [W-1:0]  HALF_C = W'(1) << (F - 1);
  localparam logic signed [W-1:0]  TQ_C   = W'(3) << (F - 2);
  localparam logic [CFG_DATA_W-1:0] ONE_CFG = CFG_DATA_W'(1) << F;

  function automatic logic signed [W-1:0] sat(input logic signed [WX-1:0] v);
    if (v > SMAX_X) return SMAX_W;
    if (v < SMIN_X) return SMIN_W;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ucfg(input logic [CFG_DATA_W-1:0] v);
    logic [W+CFG_DATA_W-1:0] t;
    t = {{W{1'b0}}, v};
    return $signed(t[W-1:0]);
  endfunction

  state_t state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uinst_t u;

  logic [CFG_DATA_W-1:0] vm_r, acc_r, ramp_r;

  logic               cmd_r;
  logic [31:0]        now_r;
  logic signed [31:0] goal_r, srcd_r, srcv_r, srca_r;

  logic               dir_r, flag_r;
  logic [2:0]         phase_r;
  logic [31:0]        last_r;
  logic signed [W-1:0] j_r, p_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  logic signed [W-1:0] dsp_r, vsp_r, asp_r, x0_r, x1_r, x2_r;

  logic               out_valid_r;
  logic [31:0]        out_d_r, out_v_r, out_a_r;
  logic [2:0]         out_ph_r;

  logic               it_sqrt_r, it_neg_r, it_zero_r, it_aneg_r;
  logic [CW-1:0]      it_cnt_r;
  logic [XW-1:0]      it_x_r;
  logic [RW-1:0]      it_rem_r;
  logic [QW-1:0]      it_q_r;
  logic [W-1:0]       it_d_r;

  logic signed [W-1:0]  opa, opb, alu_res, it_res, wb_val;
  logic signed [WX-1:0] ea, eb, amag, bmag, qx;
  logic signed [W2-1:0] mul_p, mul_s;
  logic signed [33:0]   dt34;
  logic [DV-1:0]        dvd;
  logic [RW-1:0]        rem2, trial, rem_n;
  logic                 ge;
  logic                 in_ready, can_out, done_fire, it_start, wb_en, exec_wr;

  assign u = ucode(pc_r);
  assign dt34 = $signed({2'b00, now_r}) - $signed({2'b00, last_r});

  function automatic logic signed [W-1:0] pick(input src_t s);
    logic signed [W-1:0] r;
    case (s)
      S_ZERO:  r = '0;
      S_HALF:  r = HALF_C;
      S_TQ:    r = TQ_C;
      S_VM:    r = ucfg(vm_r);
      S_A:     r = ucfg(acc_r);
      S_T:     r = ucfg(ramp_r);
      S_J:     r = j_r;
      S_P:     r = p_r;
      S_T2:    r = t2_r;
      S_T3:    r = t3_r;
      S_T4:    r = t4_r;
      S_T5:    r = t5_r;
      S_T6:    r = t6_r;
      S_T7:    r = t7_r;
      S_DSP:   r = dsp_r;
      S_VSP:   r = vsp_r;
      S_ASP:   r = asp_r;
      S_X0:    r = x0_r;
      S_X1:    r = x1_r;
      S_X2:    r = x2_r;
      S_GOAL:  r = W'(goal_r);
      S_SRCD:  r = W'(srcd_r);
      S_SRCV:  r = W'(srcv_r);
      S_SRCA:  r = W'(srca_r);
      S_NOW:   r = sat(WX'($signed({1'b0, now_r})));
      S_DT:    r = sat(WX'(dt34));
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(u.a);
    opb = pick(u.b);
  end

  // combinational ALU
  always_comb begin
    ea    = WX'(opa);
    eb    = WX'(opb);
    mul_p = W2'(opa) * W2'(opb);
    mul_s = mul_p >>> F;
    case (u.op)
      OP_ADD:  alu_res = sat(ea + eb);
      OP_SUB:  alu_res = sat(ea - eb);
      OP_MUL:  alu_res = sat(WX'(mul_s));
      OP_ABS:  alu_res = opa[W-1] ? sat(-ea) : opa;
      OP_MAX0: alu_res = opa[W-1] ? '0 : opa;
      OP_NEGD: alu_res = dir_r ? sat(-ea) : opa;
      default: alu_res = opa;
    endcase
  end

  // divide / sqrt setup and one step
  always_comb begin
    amag = opa[W-1] ? -ea : ea;
    bmag = opb[W-1] ? -eb : eb;
    dvd  = {amag[W-1:0], {F{1'b0}}};
    if (it_sqrt_r) begin
      rem2  = {it_rem_r[RW-3:0], it_x_r[XW-1:XW-2]};
      trial = RW'({it_q_r, 2'b01});
    end else begin
      rem2  = {it_rem_r[RW-2:0], it_x_r[XW-1]};
      trial = RW'(it_d_r);
    end
    ge    = rem2 >= trial;
    rem_n = ge ? rem2 - trial : rem2;
    qx    = $signed(WX'(it_q_r));
    if (it_sqrt_r) begin
      it_res = sat(qx);
    end else if (it_zero_r) begin
      it_res = it_aneg_r ? SMIN_W : SMAX_W;
    end else begin
      it_res = sat(it_neg_r ? -qx : qx);
    end
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    can_out   = !out_valid_r || out_ch.ready;
    done_fire = (state_r == ST_EXEC) && (u.op == OP_DONE) && can_out;
    it_start  = (state_r == ST_EXEC) && (u.op inside {OP_DIV, OP_SQRT});
    exec_wr   = (state_r == ST_EXEC) &&
                (u.op inside {OP_ADD, OP_SUB, OP_MUL, OP_ABS, OP_MAX0, OP_MOV, OP_NEGD});
    wb_en     = exec_wr || ((state_r == ST_ITER) && (it_cnt_r == '0));
    wb_val    = (state_r == ST_ITER) ? it_res : alu_res;
  end

  assign in_ch.ready                  = in_ready;
  assign out_ch.valid                 = out_valid_r;
  assign out_ch.setpoint_displacement = out_d_r;
  assign out_ch.setpoint_velocity     = out_v_r;
  assign out_ch.setpoint_acceleration = out_a_r;
  assign out_ch.profile_phase         = out_ph_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      ST_IDLE: begin
        pc_nxt = '0;
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (u.op)
          OP_DIV, OP_SQRT: state_nxt = ST_ITER;
          OP_BR:   pc_nxt = flag_r ? u.imm : pc_r + 1'b1;
          OP_BCMD: pc_nxt = (cmd_r == CMD_UPDATE) ? u.imm : pc_r + 1'b1;
          OP_JMP:  pc_nxt = u.imm;
          OP_DONE: begin
            if (can_out) begin
              state_nxt = ST_IDLE;
              pc_nxt    = '0;
            end
          end
          default: pc_nxt = pc_r + 1'b1;
        endcase
      end
      ST_ITER: begin
        if (it_cnt_r == '0) begin
          state_nxt = ST_EXEC;
          pc_nxt    = pc_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      vm_r        <= ONE_CFG;
      acc_r       <= ONE_CFG;
      ramp_r      <= ONE_CFG;
      dir_r       <= 1'b0;
      flag_r      <= 1'b0;
      phase_r     <= '0;
      last_r      <= '0;
      p_r         <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      t4_r        <= '0;
      t5_r        <= '0;
      t6_r        <= '0;
      t7_r        <= '0;
      dsp_r       <= '0;
      vsp_r       <= '0;
      asp_r       <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAX_VELOCITY:     vm_r   <= cfg_wdata;
          CFG_MAX_ACCELERATION: acc_r  <= cfg_wdata;
          CFG_ACCEL_RAMP_TIME:  ramp_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
        last_r      <= now_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_EXEC) begin
        case (u.op)
          OP_ABS:  dir_r   <= opa[W-1];
          OP_CLT:  flag_r  <= opa < opb;
          OP_CGT:  flag_r  <= opa > opb;
          OP_PH:   phase_r <= u.imm[2:0];
          default: ;
        endcase
      end
      if (wb_en) begin
        case (u.d)
          S_P:     p_r   <= wb_val;
          S_T2:    t2_r  <= wb_val;
          S_T3:    t3_r  <= wb_val;
          S_T4:    t4_r  <= wb_val;
          S_T5:    t5_r  <= wb_val;
          S_T6:    t6_r  <= wb_val;
          S_T7:    t7_r  <= wb_val;
          S_DSP:   dsp_r <= wb_val;
          S_VSP:   vsp_r <= wb_val;
          S_ASP:   asp_r <= wb_val;
          default: ;
        endcase
      end
    end
  end

  // payload, output, scratch and divide/sqrt registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      cmd_r  <= in_ch.cmd;
      now_r  <= in_ch.time_now;
      goal_r <= in_ch.goal_displacement;
      srcd_r <= in_ch.source_displacement;
      srcv_r <= in_ch.source_velocity;
      srca_r <= in_ch.source_acceleration;
    end
    if (done_fire) begin
      out_d_r  <= 32'(dsp_r);
      out_v_r  <= 32'(vsp_r);
      out_a_r  <= 32'(asp_r);
      out_ph_r <= phase_r;
    end
    if (wb_en) begin
      case (u.d)
        S_J:     j_r  <= wb_val;
        S_X0:    x0_r <= wb_val;
        S_X1:    x1_r <= wb_val;
        S_X2:    x2_r <= wb_val;
        default: ;
      endcase
    end
    if (it_start) begin
      it_sqrt_r <= (u.op == OP_SQRT);
      it_rem_r  <= '0;
      it_q_r    <= '0;
      it_d_r    <= bmag[W-1:0];
      it_neg_r  <= opa[W-1] ^ opb[W-1];
      it_zero_r <= (opb == '0);
      it_aneg_r <= opa[W-1];
      if (u.op == OP_SQRT) begin
        it_cnt_r <= CW'(NS);
        it_x_r   <= opa[W-1] ? '0 : XW'({opa[W-1:0], {F{1'b0}}});
      end else begin
        it_cnt_r <= CW'(DV);
        it_x_r   <= XW'(dvd) << (XW - DV);
      end
    end else if ((state_r == ST_ITER) && (it_cnt_r != '0)) begin
      it_cnt_r <= it_cnt_r - 1'b1;
      it_rem_r <= rem_n;
      it_q_r   <= {it_q_r[QW-2:0], ge};
      it_x_r   <= it_sqrt_r ? (it_x_r << 2) : (it_x_r << 1);
    end
  end

endmodule

// ===== sim/s_curve_motion_profile_tb.sv =====
module s_curve_motion_profile_tb import scmp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd1 << SCMP_FRAC_BITS;
  localparam longint HALF = 64'sd1 << (SCMP_FRAC_BITS - 1);
  localparam longint TQ = 64'sd3 << (SCMP_FRAC_BITS - 2);
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic        cmd;
    logic [31:0] time_now;
    logic [31:0] goal;
    logic [31:0] src_d;
    logic [31:0] src_v;
    logic [31:0] src_a;
  } motion_cmd_t;

  typedef struct packed {
    logic [31:0] disp;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [2:0]  phase;
  } setpoint_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  scmp_in_if  in_ch();
  scmp_out_if out_ch();

  s_curve_motion_profile dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // profile state mirror
  longint vmax, amax, tramp, jrk, peak, dsp, vsp, asp, t_last;
  longint tph[6];
  bit neg_dir;

  setpoint_t expected_sp[$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return sat(p / ONE);
    return sat(-((-p + ONE - 1) / ONE));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) return (a < 0) ? SMIN : SMAX;
    return sat((a * ONE) / b);
  endfunction

  function automatic longint fx_sqrt(longint a);
    longint unsigned x, r, bt;
    if (a <= 0) return 0;
    x = longint'(a) << SCMP_FRAC_BITS;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return sat(longint'(r));
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic void reset_profile();
    vmax = ONE;
    amax = ONE;
    tramp = ONE;
    jrk = fx_div(amax, tramp);
    neg_dir = 1'b0;
    peak = 0;
    foreach (tph[i]) tph[i] = 0;
    dsp = 0;
    vsp = 0;
    asp = 0;
    t_last = 0;
  endfunction

  function automatic setpoint_t next_setpoint(motion_cmd_t c);
    longint now, d, m, arg, t, a, v, e;
    bit short_move;
    setpoint_t r;
    now = longint'({32'd0, c.time_now});
    if (c.cmd == CMD_SET_GOAL) begin
      d = sat(sx(c.goal) - sx(c.src_d));
      neg_dir = d < 0;
      m = (d < 0) ? sat(-d) : d;
      short_move = fx_mul(vmax, sat(tramp + fx_div(vmax, amax))) > m;
      if (short_move) begin
        arg = sat(fx_div(m, amax) - fx_mul(TQ, fx_mul(tramp, tramp)));
        if (arg < 0) arg = 0;
        peak = fx_mul(amax, sat(fx_sqrt(arg) - fx_mul(HALF, tramp)));
        if (peak < 0) peak = 0;
      end else begin
        peak = vmax;
      end
      tph[0] = fx_div(peak, amax);
      tph[1] = sat(tph[0] + tramp);
      tph[2] = short_move ? tph[1] : fx_div(m, peak);
      tph[3] = sat(tph[2] + tramp);
      tph[4] = sat(tph[2] + tph[0]);
      tph[5] = sat(tph[4] + tramp);
      t_last = now;
      dsp = sx(c.src_d);
      vsp = sx(c.src_v);
      asp = sx(c.src_a);
      r.phase = 3'd0;
    end else begin
      t = sat(now);
      if (t < tramp) begin
        r.phase = 3'd0;
        a = fx_mul(jrk, t);
        v = fx_mul(HALF, fx_mul(jrk, fx_mul(t, t)));
      end else if (t < tph[0]) begin
        r.phase = 3'd1;
        a = amax;
        v = fx_mul(amax, sat(t - fx_mul(HALF, tramp)));
      end else if (t < tph[1]) begin
        r.phase = 3'd2;
        a = sat(amax - fx_mul(jrk, sat(t - tph[0])));
        e = sat(tph[1] - t);
        v = sat(peak - fx_mul(HALF, fx_mul(jrk, fx_mul(e, e))));
      end else if (t < tph[2]) begin
        r.phase = 3'd3;
        a = 0;
        v = peak;
      end else if (t < tph[3]) begin
        r.phase = 3'd4;
        e = sat(t - tph[2]);
        a = sat(-fx_mul(jrk, e));
        v = sat(peak - fx_mul(HALF, fx_mul(jrk, fx_mul(e, e))));
      end else if (t < tph[4]) begin
        r.phase = 3'd5;
        a = sat(-amax);
        v = sat(sat(peak - fx_mul(HALF, fx_mul(amax, tramp)))
                - fx_mul(amax, sat(t - tph[3])));
      end else if (t < tph[5]) begin
        r.phase = 3'd6;
        e = sat(tph[5] - t);
        a = sat(-fx_mul(jrk, e));
        v = fx_mul(HALF, fx_mul(jrk, fx_mul(e, e)));
      end else begin
        r.phase = 3'd7;
        a = 0;
        v = 0;
      end
      if (neg_dir) begin
        a = sat(-a);
        v = sat(-v);
      end
      dsp = sat(dsp + fx_mul(v, sat(now - t_last)));
      vsp = v;
      asp = a;
      t_last = now;
    end
    r.disp = dsp[31:0];
    r.vel = vsp[31:0];
    r.acc = asp[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    setpoint_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.disp = out_ch.setpoint_displacement;
      got.vel = out_ch.setpoint_velocity;
      got.acc = out_ch.setpoint_acceleration;
      got.phase = out_ch.profile_phase;
      if (expected_sp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected setpoint %h", got);
      end else begin
        want = expected_sp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("setpoint mismatch: exp d=%h v=%h a=%h ph=%0d got d=%h v=%h a=%h ph=%0d",
                     want.disp, want.vel, want.acc, want.phase,
                     got.disp, got.vel, got.acc, got.phase);
        end
      end
    end
  end

  task automatic send_item(motion_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c.cmd;
    in_ch.time_now <= c.time_now;
    in_ch.goal_displacement <= c.goal;
    in_ch.source_displacement <= c.src_d;
    in_ch.source_velocity <= c.src_v;
    in_ch.source_acceleration <= c.src_a;
    do @(posedge clk); while (!in_ch.ready);
    expected_sp.push_back(next_setpoint(c));
  endtask

  task automatic set_goal(logic [31:0] goal, logic [31:0] src, logic [31:0] at);
    motion_cmd_t c;
    c.cmd = CMD_SET_GOAL;
    c.time_now = at;
    c.goal = goal;
    c.src_d = src;
    c.src_v = $urandom;
    c.src_a = $urandom;
    send_item(c);
  endtask

  task automatic update_at(logic [31:0] at);
    motion_cmd_t c;
    c.cmd = CMD_UPDATE;
    c.time_now = at;
    c.goal = $urandom;
    c.src_d = $urandom;
    c.src_v = $urandom;
    c.src_a = $urandom;
    send_item(c);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_sp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(logic [30:0] vm, logic [30:0] acc, logic [30:0] ramp);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_VELOCITY;
    cfg_wdata <= vm;
    @(posedge clk);
    vmax = vm;
    jrk = fx_div(amax, tramp);
    cfg_index <= CFG_MAX_ACCELERATION;
    cfg_wdata <= acc;
    @(posedge clk);
    amax = acc;
    jrk = fx_div(amax, tramp);
    cfg_index <= CFG_ACCEL_RAMP_TIME;
    cfg_wdata <= ramp;
    @(posedge clk);
    tramp = ramp;
    jrk = fx_div(amax, tramp);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    update_at(32'h0000_8000);
    set_goal(32'h000A_0000, 32'h0, 32'h0);
    update_at(32'h0000_8000);
    update_at(32'h0001_8000);
    update_at(32'h0005_0000);
    update_at(32'h000A_8000);
    update_at(32'h000B_4000);
    update_at(32'h000D_0000);
    update_at(32'h0004_0000);
    update_at(32'hFFFF_FFFF);
    set_goal(32'hFFFF_0000, 32'h0, 32'h0);
    update_at(32'h0000_4000);
    update_at(32'h0001_0000);
    set_goal(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    update_at(32'h0002_0000);
    update_at(32'h8000_0000);
    set_goal(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    update_at(32'h7FFF_FFFF);
    update_at(32'h0);
    set_goal(32'h0000_8000, 32'h0, 32'h0);
    update_at(32'h0000_4000);
  endtask

  task automatic run_profiles(int n_items);
    int sent, k;
    longint t_end, t, step;
    logic [31:0] src, span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(1)) update_at($urandom);
        else set_goal($urandom, $urandom, $urandom);
        sent++;
      end else begin
        src = $urandom_range(1) ? ($urandom & 32'h00FF_FFFF) : $urandom;
        span = $urandom & ($urandom_range(1) ? 32'h003F_FFFF : 32'h0003_FFFF);
        if ($urandom_range(1)) span = -span;
        set_goal(src + span, src, 32'h0);
        k = $urandom_range(5, 15);
        t_end = tph[5] + tramp + tramp / 4;
        if (t_end > 64'hFFFF_FFFF) t_end = 64'hFFFF_FFFF;
        step = t_end / k + 1;
        t = 0;
        repeat (k) begin
          t = t + $urandom_range(0, 32'(step > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : step));
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
          if ($urandom_range(19) == 0) update_at(32'(t / 2));
          else update_at(32'(t));
        end
        sent += k + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) update_at($urandom_range(0, 32'h0004_0000));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MAX_VELOCITY;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SET_GOAL;
    in_ch.time_now = '0;
    in_ch.goal_displacement = '0;
    in_ch.source_displacement = '0;
    in_ch.source_velocity = '0;
    in_ch.source_acceleration = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    reset_profile();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    run_profiles(130);

    write_limits(31'h0003_0000, 31'h0002_0000, 31'h0000_4000);
    send_idle_pct = 74;
    run_profiles(130);

    write_limits(31'd1, 31'h7FFF_FFFF, 31'h0001_0000);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    run_profiles(120);

    write_limits(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    run_profiles(100);

    write_limits(31'h0002_0000, 31'h0001_8000, 31'h0000_8000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    run_profiles(120);

    write_limits(31'd1, 31'd1, 31'd1);
    run_profiles(30);

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/scmp_pkg.sv
rtl/scmp_if.sv
rtl/s_curve_motion_profile.sv
sim/s_curve_motion_profile_tb.sv
